>>> src/tgde_pkg.sv
`timescale 1ns / 1ps
// tgde_pkg: shared types, constants and the 5x7 font rom of the glyph dot expander
// no dependencies
package tgde_pkg;

	localparam int DEF_MAX_SCALE = 16;

	localparam int XW = 18;
	localparam int YW = 15;
	localparam int PXW = 16;
	localparam int PYW = 13;

	localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [1:0] REG_DOT_SCALE    = 2'd2;

	localparam logic [12:0] RST_FRAME_WIDTH  = 13'd640;
	localparam logic [12:0] RST_FRAME_HEIGHT = 13'd480;
	localparam logic [4:0]  RST_DOT_SCALE    = 5'd1;
	localparam logic [12:0] FRAME_LIMIT      = 13'd4096;
	localparam logic signed [PXW:0] PEN_MAX  = 17'sd32767;

	localparam logic [2:0] ROW_LAST = 3'd6;
	localparam logic [2:0] COL_LAST = 3'd4;

	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_DASH  = 8'h2D;
	localparam logic [7:0] CHAR_SLASH = 8'h2F;
	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_0     = 8'h30;
	localparam logic [7:0] CHAR_9     = 8'h39;
	localparam logic [7:0] CHAR_UA    = 8'h41;
	localparam logic [7:0] CHAR_UZ    = 8'h5A;
	localparam logic [7:0] CHAR_LA    = 8'h61;
	localparam logic [7:0] CHAR_LZ    = 8'h7A;

	localparam logic [4:0] DIGIT_ROM [0:9][0:6] = '{
		'{5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14},
		'{5'd4,  5'd12, 5'd4,  5'd4,  5'd4,  5'd4,  5'd14},
		'{5'd14, 5'd17, 5'd1,  5'd2,  5'd4,  5'd8,  5'd31},
		'{5'd30, 5'd1,  5'd1,  5'd14, 5'd1,  5'd1,  5'd30},
		'{5'd2,  5'd6,  5'd10, 5'd18, 5'd31, 5'd2,  5'd2},
		'{5'd31, 5'd16, 5'd30, 5'd1,  5'd1,  5'd17, 5'd14},
		'{5'd6,  5'd8,  5'd16, 5'd30, 5'd17, 5'd17, 5'd14},
		'{5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd8,  5'd8},
		'{5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14},
		'{5'd14, 5'd17, 5'd17, 5'd15, 5'd1,  5'd2,  5'd12}
	};

	localparam logic [4:0] LETTER_ROM [0:25][0:6] = '{
		'{5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17},
		'{5'd30, 5'd17, 5'd17, 5'd30, 5'd17, 5'd17, 5'd30},
		'{5'd14, 5'd17, 5'd16, 5'd16, 5'd16, 5'd17, 5'd14},
		'{5'd30, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd30},
		'{5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31},
		'{5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd16},
		'{5'd14, 5'd17, 5'd16, 5'd23, 5'd17, 5'd17, 5'd15},
		'{5'd17, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17},
		'{5'd14, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd14},
		'{5'd7,  5'd2,  5'd2,  5'd2,  5'd2,  5'd18, 5'd12},
		'{5'd17, 5'd18, 5'd20, 5'd24, 5'd20, 5'd18, 5'd17},
		'{5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd31},
		'{5'd17, 5'd27, 5'd21, 5'd21, 5'd17, 5'd17, 5'd17},
		'{5'd17, 5'd25, 5'd21, 5'd19, 5'd17, 5'd17, 5'd17},
		'{5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14},
		'{5'd30, 5'd17, 5'd17, 5'd30, 5'd16, 5'd16, 5'd16},
		'{5'd14, 5'd17, 5'd17, 5'd17, 5'd21, 5'd18, 5'd13},
		'{5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17},
		'{5'd15, 5'd16, 5'd16, 5'd14, 5'd1,  5'd1,  5'd30},
		'{5'd31, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4},
		'{5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14},
		'{5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd10, 5'd4},
		'{5'd17, 5'd17, 5'd17, 5'd21, 5'd21, 5'd21, 5'd10},
		'{5'd17, 5'd17, 5'd10, 5'd4,  5'd10, 5'd17, 5'd17},
		'{5'd17, 5'd17, 5'd10, 5'd4,  5'd4,  5'd4,  5'd4},
		'{5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd16, 5'd31}
	};

	localparam logic [4:0] DASH_ROM  [0:6] = '{5'd0, 5'd0, 5'd0, 5'd31, 5'd0, 5'd0, 5'd0};
	localparam logic [4:0] SLASH_ROM [0:6] = '{5'd16, 5'd16, 5'd16, 5'd8, 5'd4, 5'd2, 5'd1};
	localparam logic [4:0] COLON_ROM [0:6] = '{5'd0, 5'd0, 5'd4, 5'd0, 5'd4, 5'd0, 5'd0};

	typedef struct packed {
		logic       load;
		logic       step;
		logic       flush;
		logic [2:0] row;
		logic [2:0] col;
	} tgde_cmd_t;

	typedef struct packed {
		logic in_space;
		logic hit;
		logic pend_valid;
		logic out_free;
	} tgde_sts_t;

	typedef struct packed {
		logic [4:0]  h;
		logic [4:0]  w;
		logic [11:0] y;
		logic [11:0] x;
	} tgde_rect_t;

	// row word of the font, bit 4 is the leftmost column
	function automatic logic [4:0] glyph_row(input logic [7:0] c, input logic [2:0] row);
		logic [7:0] d;
		logic [7:0] u;
		logic [7:0] l;
		logic [4:0] r;
		d = c - CHAR_0;
		u = c - CHAR_UA;
		l = c - CHAR_LA;
		r = '0;
		if (c >= CHAR_0 && c <= CHAR_9) begin
			r = DIGIT_ROM[d[3:0]][row];
		end else if (c >= CHAR_UA && c <= CHAR_UZ) begin
			r = LETTER_ROM[u[4:0]][row];
		end else if (c >= CHAR_LA && c <= CHAR_LZ) begin
			r = LETTER_ROM[l[4:0]][row];
		end else if (c == CHAR_DASH) begin
			r = DASH_ROM[row];
		end else if (c == CHAR_SLASH) begin
			r = SLASH_ROM[row];
		end else if (c == CHAR_COLON) begin
			r = COLON_ROM[row];
		end
		return r;
	endfunction

endpackage

>>> src/tgde_ctrl.sv
`timescale 1ns / 1ps
// tgde_ctrl: controller that walks the 7x5 dot grid of one character
// depends on tgde_pkg
module tgde_ctrl
	import tgde_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	input  tgde_sts_t sts,
	output tgde_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	state_t     state_q;
	logic [2:0] row_q;
	logic [2:0] col_q;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		cmd = '0;
		cmd.row = row_q;
		cmd.col = col_q;
		cmd.load = s_tvalid && s_tready;
		cmd.step = (state_q == ST_SCAN) && !(sts.hit && sts.pend_valid && !sts.out_free);
		cmd.flush = (state_q == ST_FLUSH) && (!sts.pend_valid || sts.out_free);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q <= '0;
			col_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.load && !sts.in_space) begin
						state_q <= ST_SCAN;
						row_q <= '0;
						col_q <= '0;
					end
				end
				ST_SCAN: begin
					if (cmd.step) begin
						if (col_q == COL_LAST) begin
							col_q <= '0;
							if (row_q == ROW_LAST) begin
								state_q <= ST_FLUSH;
							end else begin
								row_q <= row_q + 3'd1;
							end
						end else begin
							col_q <= col_q + 3'd1;
						end
					end
				end
				ST_FLUSH: begin
					if (cmd.flush) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_scan_ends_in_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && cmd.step && row_q == ROW_LAST && col_q == COL_LAST)
		|=> state_q == ST_FLUSH)
		else $error("grid walk did not close after the last dot");
	a_grid_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(row_q <= ROW_LAST) && (col_q <= COL_LAST))
		else $error("dot counter out of grid");
`endif

endmodule

>>> src/tgde_dp.sv
`timescale 1ns / 1ps
// tgde_dp: config registers, pen, dot clipping, pending rectangle and output register
// depends on tgde_pkg
module tgde_dp
	import tgde_pkg::*;
#(
	parameter int MAX_SCALE = DEF_MAX_SCALE
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data,
	input  logic [39:0] s_tdata,
	input  logic        s_tuser,
	input  tgde_cmd_t   cmd,
	output tgde_sts_t   sts,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,
	output logic        m_tlast
);

	localparam int SW = $clog2(MAX_SCALE + 1);
	localparam int EW = (SW > 5) ? SW : 5;
	localparam int AW = SW + 3;

	logic [12:0] frame_width_q;
	logic [12:0] frame_height_q;
	logic [4:0]  dot_scale_q;

	logic signed [PXW-1:0] pen_x_q;
	logic signed [PYW-1:0] pen_y_q;
	logic signed [XW-1:0]  dot_x_q;
	logic signed [YW-1:0]  dot_y_q;
	logic [7:0]            char_q;

	tgde_rect_t pend_rect_q;
	logic       pend_valid_q;
	tgde_rect_t out_rect_q;
	logic       out_last_q;
	logic       out_valid_q;

	logic [EW-1:0] scale_ext;
	logic [SW-1:0] scale;
	logic signed [XW-1:0] scale_x;
	logic signed [YW-1:0] scale_y;
	logic [12:0] fw;
	logic [12:0] fh;
	logic [AW-1:0] adv_space;
	logic [AW-1:0] adv_glyph;

	logic [7:0] in_char;
	logic signed [12:0] in_ox;
	logic signed [12:0] in_oy;
	logic signed [PXW-1:0] base_x;
	logic signed [PYW-1:0] base_y;
	logic signed [PXW:0] sum_space;
	logic signed [PXW:0] sum_glyph;
	logic signed [PXW-1:0] pen_space;
	logic signed [PXW-1:0] pen_glyph;

	logic [4:0] bits;
	logic       lit;
	logic signed [XW-1:0] x1;
	logic signed [XW-1:0] x0c;
	logic signed [XW-1:0] x1c;
	logic signed [XW-1:0] xd;
	logic signed [XW-1:0] fw_x;
	logic signed [YW-1:0] y1;
	logic signed [YW-1:0] y0c;
	logic signed [YW-1:0] y1c;
	logic signed [YW-1:0] yd;
	logic signed [YW-1:0] fh_y;
	logic       hit;
	tgde_rect_t cur_rect;

	logic push_mid;
	logic push_end;
	logic push;
	logic out_free;

	assign scale_ext = EW'(dot_scale_q);
	assign scale = (scale_ext > EW'(MAX_SCALE)) ? SW'(MAX_SCALE) : SW'(scale_ext);
	assign scale_x = signed'(XW'(scale));
	assign scale_y = signed'(YW'(scale));
	assign fw = (frame_width_q > FRAME_LIMIT) ? FRAME_LIMIT : frame_width_q;
	assign fh = (frame_height_q > FRAME_LIMIT) ? FRAME_LIMIT : frame_height_q;
	assign fw_x = signed'(XW'(fw));
	assign fh_y = signed'(YW'(fh));
	assign adv_space = AW'({scale, 2'b00});
	assign adv_glyph = AW'({scale, 2'b00}) + AW'({scale, 1'b0});

	assign in_char = s_tdata[7:0];
	assign in_ox = s_tdata[20:8];
	assign in_oy = s_tdata[33:21];
	assign base_x = s_tuser ? PXW'(in_ox) : pen_x_q;
	assign base_y = s_tuser ? in_oy : pen_y_q;

	// pen advance saturates at the top of its range
	assign sum_space = (PXW+1)'(base_x) + signed'((PXW+1)'(adv_space));
	assign sum_glyph = (PXW+1)'(pen_x_q) + signed'((PXW+1)'(adv_glyph));
	assign pen_space = (sum_space > PEN_MAX) ? PEN_MAX[PXW-1:0] : sum_space[PXW-1:0];
	assign pen_glyph = (sum_glyph > PEN_MAX) ? PEN_MAX[PXW-1:0] : sum_glyph[PXW-1:0];

	// clip the current dot against the frame
	assign bits = glyph_row(char_q, cmd.row);
	assign lit = bits[3'd4 - cmd.col];
	assign x1 = dot_x_q + scale_x;
	assign x0c = dot_x_q[XW-1] ? '0 : dot_x_q;
	assign x1c = (x1 > fw_x) ? fw_x : x1;
	assign xd = x1c - x0c;
	assign y1 = dot_y_q + scale_y;
	assign y0c = dot_y_q[YW-1] ? '0 : dot_y_q;
	assign y1c = (y1 > fh_y) ? fh_y : y1;
	assign yd = y1c - y0c;
	assign hit = lit && (x1c > x0c) && (y1c > y0c);

	always_comb begin
		cur_rect.x = x0c[11:0];
		cur_rect.y = y0c[11:0];
		cur_rect.w = xd[4:0];
		cur_rect.h = yd[4:0];
	end

	assign out_free = !out_valid_q || m_tready;
	assign push_mid = cmd.step && hit && pend_valid_q;
	assign push_end = cmd.flush && pend_valid_q;
	assign push = push_mid || push_end;

	always_comb begin
		sts.in_space = (in_char == CHAR_SPACE);
		sts.hit = hit;
		sts.pend_valid = pend_valid_q;
		sts.out_free = out_free;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {6'b0, out_rect_q};
	assign m_tlast = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q <= RST_FRAME_WIDTH;
			frame_height_q <= RST_FRAME_HEIGHT;
			dot_scale_q <= RST_DOT_SCALE;
			pen_x_q <= '0;
			pen_y_q <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_FRAME_WIDTH:  frame_width_q <= cfg_data;
					REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
					REG_DOT_SCALE:    dot_scale_q <= cfg_data[4:0];
					default: ;
				endcase
			end
			if (cmd.load) begin
				pen_y_q <= base_y;
				pen_x_q <= (in_char == CHAR_SPACE) ? pen_space : base_x;
			end else if (cmd.flush) begin
				pen_x_q <= pen_glyph;
			end
			if (cmd.step && hit) begin
				pend_valid_q <= 1'b1;
			end else if (cmd.flush) begin
				pend_valid_q <= 1'b0;
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			char_q <= in_char;
			dot_x_q <= XW'(base_x);
			dot_y_q <= YW'(base_y);
		end else if (cmd.step) begin
			if (cmd.col == COL_LAST) begin
				dot_x_q <= XW'(pen_x_q);
				dot_y_q <= y1;
			end else begin
				dot_x_q <= x1;
			end
		end
		if (cmd.step && hit) begin
			pend_rect_q <= cur_rect;
		end
		if (push) begin
			out_rect_q <= pend_rect_q;
			out_last_q <= push_end;
		end
	end

`ifndef SYNTHESIS
	a_push_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> out_free)
		else $error("rectangle pushed into a full output register");
	a_flush_empties: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |=> !pend_valid_q && out_valid_q == ($past(pend_valid_q) || ($past(out_valid_q) && !$past(m_tready))))
		else $error("pending rectangle not handed over at end of character");
`endif

endmodule

>>> src/text_glyph_dot_expander_unit.sv
`timescale 1ns / 1ps
// A character is taken in one handshake. A space only moves the pen and the block is ready
// again in the next cycle. Any other byte walks all 35 dot positions of its 5x7 glyph, one
// position per cycle through the dot counter of the controller, stalling while a lit dot
// meets a full output register, and closes with a flush that hands over the final rectangle
// and advances the pen once the final rectangle has room. Rectangles leave one per transfer
// in row-major order through an output register; the last one of a character carries tlast.
// Characters that draw nothing, or whose dots all fall outside the frame, give no transfer.
// top level: depends on tgde_pkg, tgde_ctrl, tgde_dp
module text_glyph_dot_expander_unit
	import tgde_pkg::*;
#(
	parameter int MAX_SCALE = DEF_MAX_SCALE
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // char_code, origin_x, origin_y
	input  logic        s_tuser,   // new_text
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // rect_x, rect_y, rect_w, rect_h
	output logic        m_tlast
);

	tgde_cmd_t cmd;
	tgde_sts_t sts;

	tgde_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tgde_dp #(
		.MAX_SCALE (MAX_SCALE)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cmd       (cmd),
		.sts       (sts),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

>>> tb/text_glyph_dot_expander_unit_tb.sv
`timescale 1ns / 1ps
// self-checking bench for text_glyph_dot_expander_unit: characters in, clipped dot rectangles out
// a local glyph renderer predicts the rectangles of all but the typed rows; depends on tgde_pkg and the unit under test
module text_glyph_dot_expander_unit_tb;
	import tgde_pkg::*;

	localparam int MAX_DOT       = 16;
	localparam int FRAME_CAP     = 4096;
	localparam int PEN_LIMIT     = 32767;
	localparam int SPACE_STEP    = 4;
	localparam int GLYPH_STEP    = 6;
	localparam int SETTLE_CYCLES = 80;
	localparam int QUIET_LIMIT   = 3000;

	localparam logic [1:0] REG_UNUSED = 2'd3;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LZ    = 8'h7A;

	localparam int GLYPH_DASH  = 36;
	localparam int GLYPH_SLASH = 37;
	localparam int GLYPH_COLON = 38;

	// digits, letters, then dash, slash, colon; bit 4 is the leftmost column
	localparam logic [4:0] FONT [0:38][0:6] = '{
		'{5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14},
		'{5'd4,  5'd12, 5'd4,  5'd4,  5'd4,  5'd4,  5'd14},
		'{5'd14, 5'd17, 5'd1,  5'd2,  5'd4,  5'd8,  5'd31},
		'{5'd30, 5'd1,  5'd1,  5'd14, 5'd1,  5'd1,  5'd30},
		'{5'd2,  5'd6,  5'd10, 5'd18, 5'd31, 5'd2,  5'd2},
		'{5'd31, 5'd16, 5'd30, 5'd1,  5'd1,  5'd17, 5'd14},
		'{5'd6,  5'd8,  5'd16, 5'd30, 5'd17, 5'd17, 5'd14},
		'{5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd8,  5'd8},
		'{5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14},
		'{5'd14, 5'd17, 5'd17, 5'd15, 5'd1,  5'd2,  5'd12},
		'{5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17},
		'{5'd30, 5'd17, 5'd17, 5'd30, 5'd17, 5'd17, 5'd30},
		'{5'd14, 5'd17, 5'd16, 5'd16, 5'd16, 5'd17, 5'd14},
		'{5'd30, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd30},
		'{5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31},
		'{5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd16},
		'{5'd14, 5'd17, 5'd16, 5'd23, 5'd17, 5'd17, 5'd15},
		'{5'd17, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17},
		'{5'd14, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd14},
		'{5'd7,  5'd2,  5'd2,  5'd2,  5'd2,  5'd18, 5'd12},
		'{5'd17, 5'd18, 5'd20, 5'd24, 5'd20, 5'd18, 5'd17},
		'{5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd31},
		'{5'd17, 5'd27, 5'd21, 5'd21, 5'd17, 5'd17, 5'd17},
		'{5'd17, 5'd25, 5'd21, 5'd19, 5'd17, 5'd17, 5'd17},
		'{5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14},
		'{5'd30, 5'd17, 5'd17, 5'd30, 5'd16, 5'd16, 5'd16},
		'{5'd14, 5'd17, 5'd17, 5'd17, 5'd21, 5'd18, 5'd13},
		'{5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17},
		'{5'd15, 5'd16, 5'd16, 5'd14, 5'd1,  5'd1,  5'd30},
		'{5'd31, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4},
		'{5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14},
		'{5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd10, 5'd4},
		'{5'd17, 5'd17, 5'd17, 5'd21, 5'd21, 5'd21, 5'd10},
		'{5'd17, 5'd17, 5'd10, 5'd4,  5'd10, 5'd17, 5'd17},
		'{5'd17, 5'd17, 5'd10, 5'd4,  5'd4,  5'd4,  5'd4},
		'{5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd16, 5'd31},
		'{5'd0,  5'd0,  5'd0,  5'd31, 5'd0,  5'd0,  5'd0},
		'{5'd16, 5'd16, 5'd16, 5'd8,  5'd4,  5'd2,  5'd1},
		'{5'd0,  5'd0,  5'd4,  5'd0,  5'd4,  5'd0,  5'd0}
	};

	typedef struct packed {
		logic [11:0] x;
		logic [11:0] y;
		logic [4:0]  w;
		logic [4:0]  h;
		logic        last;
	} dot_rect_t;

	typedef struct packed {
		logic [7:0]  ch;
		logic        new_text;
		logic [12:0] ox;
		logic [12:0] oy;
		logic        typed;
		logic        one_rect;
		dot_rect_t   rect;
	} char_row_t;

	localparam int N_ROWS = 24;

	// typed rows carry their own expectation, the rest go through the renderer
	localparam char_row_t CHAR_ROWS [0:N_ROWS-1] = '{
		'{CH_UA,    1'b0, 13'd0,      13'd0,      1'b0, 1'b0, '0},
		'{CH_DASH,  1'b1, 13'd639,    13'd0,      1'b1, 1'b1, '{12'd639, 12'd3, 5'd1, 5'd1, 1'b1}},
		'{CH_DASH,  1'b1, -13'sd4,    13'd0,      1'b1, 1'b1, '{12'd0, 12'd3, 5'd1, 5'd1, 1'b1}},
		'{CH_SPACE, 1'b0, 13'd0,      13'd0,      1'b1, 1'b0, '0},
		'{8'h00,    1'b1, 13'd0,      13'd0,      1'b1, 1'b0, '0},
		'{8'hFF,    1'b0, 13'd4095,   13'd4095,   1'b1, 1'b0, '0},
		'{8'h80,    1'b0, 13'd0,      13'd0,      1'b1, 1'b0, '0},
		'{8'h7F,    1'b0, 13'd0,      13'd0,      1'b1, 1'b0, '0},
		'{8'h40,    1'b0, 13'd0,      13'd0,      1'b1, 1'b0, '0},
		'{CH_0,     1'b1, 13'd10,     13'd10,     1'b0, 1'b0, '0},
		'{CH_9,     1'b0, 13'd0,      13'd0,      1'b0, 1'b0, '0},
		'{CH_UZ,    1'b0, 13'd0,      13'd0,      1'b0, 1'b0, '0},
		'{CH_LA,    1'b0, 13'd0,      13'd0,      1'b0, 1'b0, '0},
		'{CH_LZ,    1'b0, 13'd0,      13'd0,      1'b0, 1'b0, '0},
		'{CH_DASH,  1'b0, 13'd0,      13'd0,      1'b0, 1'b0, '0},
		'{CH_SLASH, 1'b0, 13'd0,      13'd0,      1'b0, 1'b0, '0},
		'{CH_COLON, 1'b0, 13'd0,      13'd0,      1'b0, 1'b0, '0},
		'{8'h4D,    1'b1, 13'd4095,   13'd4095,   1'b1, 1'b0, '0},
		'{8'h57,    1'b1, -13'sd4096, -13'sd4096, 1'b1, 1'b0, '0},
		'{8'h38,    1'b1, -13'sd2,    -13'sd3,    1'b0, 1'b0, '0},
		'{8'h51,    1'b1, 13'd636,    13'd476,    1'b0, 1'b0, '0},
		'{8'h67,    1'b0, 13'd0,      13'd0,      1'b1, 1'b0, '0},
		'{8'h48,    1'b1, 13'd100,    13'd200,    1'b0, 1'b0, '0},
		'{8'h65,    1'b0, 13'd4095,   13'd4095,   1'b0, 1'b0, '0}
	};

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [12:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;   // char_code, origin_x, origin_y
	logic        s_tuser;   // new_text
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;   // rect_x, rect_y, rect_w, rect_h
	logic        m_tlast;

	logic [12:0] frame_w;
	logic [12:0] frame_h;
	logic [4:0]  dot_sc;
	int          pen_col;
	int          pen_row;

	dot_rect_t   glyph_rects[$];
	dot_rect_t   due_rects[$];
	int          mismatches = 0;
	bit          idle_on = 1'b1;
	int          stall_left = 0;
	int          quiet_cycles = 0;

	text_glyph_dot_expander_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [4:0] font_row(input logic [7:0] ch, input int row);
		int g;
		g = -1;
		if (ch >= CH_0 && ch <= CH_9) begin
			g = ch - CH_0;
		end else if (ch >= CH_UA && ch <= CH_UZ) begin
			g = 10 + ch - CH_UA;
		end else if (ch >= CH_LA && ch <= CH_LZ) begin
			g = 10 + ch - CH_LA;
		end else if (ch == CH_DASH) begin
			g = GLYPH_DASH;
		end else if (ch == CH_SLASH) begin
			g = GLYPH_SLASH;
		end else if (ch == CH_COLON) begin
			g = GLYPH_COLON;
		end
		return (g < 0) ? 5'd0 : FONT[g][row];
	endfunction

	task automatic move_pen(input int amount);
		pen_col = (pen_col + amount > PEN_LIMIT) ? PEN_LIMIT : pen_col + amount;
	endtask

	// renders one character into glyph_rects and moves the pen
	task automatic draw_glyph(input logic [7:0] ch, input logic new_text,
			input logic [12:0] ox, input logic [12:0] oy);
		int s, fw, fh, x0, y0, x1, y1, last_i;
		logic [4:0] bits;
		dot_rect_t r;
		glyph_rects.delete();
		s = (dot_sc > MAX_DOT) ? MAX_DOT : int'(dot_sc);
		fw = (frame_w > FRAME_CAP) ? FRAME_CAP : int'(frame_w);
		fh = (frame_h > FRAME_CAP) ? FRAME_CAP : int'(frame_h);
		if (new_text) begin
			pen_col = $signed(ox);
			pen_row = $signed(oy);
		end
		if (ch == CH_SPACE) begin
			move_pen(SPACE_STEP * s);
			return;
		end
		if (s > 0) begin
			for (int row = 0; row < 7; row++) begin
				bits = font_row(ch, row);
				for (int col = 0; col < 5; col++) begin
					if (bits[4 - col]) begin
						x0 = pen_col + col * s;
						y0 = pen_row + row * s;
						x1 = x0 + s;
						y1 = y0 + s;
						if (x0 < 0) x0 = 0;
						if (y0 < 0) y0 = 0;
						if (x1 > fw) x1 = fw;
						if (y1 > fh) y1 = fh;
						if (x1 > x0 && y1 > y0) begin
							r.x = 12'(x0);
							r.y = 12'(y0);
							r.w = 5'(x1 - x0);
							r.h = 5'(y1 - y0);
							r.last = 1'b0;
							glyph_rects.push_back(r);
						end
					end
				end
			end
			if (glyph_rects.size() > 0) begin
				last_i = glyph_rects.size() - 1;
				r = glyph_rects[last_i];
				r.last = 1'b1;
				glyph_rects[last_i] = r;
			end
		end
		move_pen(GLYPH_STEP * s);
	endtask

	task automatic send_char(input logic [7:0] ch, input logic new_text,
			input logic [12:0] ox, input logic [12:0] oy, input bit predicted);
		s_tvalid <= 1'b1;
		s_tdata <= {6'b0, oy, ox, ch};
		s_tuser <= new_text;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		draw_glyph(ch, new_text, ox, oy);
		if (predicted) begin
			foreach (glyph_rects[i]) due_rects.push_back(glyph_rects[i]);
		end
	endtask

	task automatic maybe_pause;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic settle;
		s_tvalid <= 1'b0;
		do @(posedge clk); while (due_rects.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [12:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_FRAME_WIDTH:  frame_w = val;
			REG_FRAME_HEIGHT: frame_h = val;
			REG_DOT_SCALE:    dot_sc = val[4:0];
			default: ;
		endcase
	endtask

	task automatic program_frame(input logic [12:0] fw, input logic [12:0] fh,
			input logic [12:0] sc);
		cfg_write(REG_FRAME_WIDTH, fw);
		cfg_write(REG_FRAME_HEIGHT, fh);
		cfg_write(REG_DOT_SCALE, sc);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [7:0] rand_char();
		case ($urandom_range(0, 9))
			0: return CH_SPACE;
			1, 2: return 8'($urandom_range(0, 255));
			3: begin
				case ($urandom_range(0, 2))
					0: return CH_DASH;
					1: return CH_SLASH;
					default: return CH_COLON;
				endcase
			end
			4, 5: return CH_0 + 8'($urandom_range(0, 9));
			6, 7: return CH_UA + 8'($urandom_range(0, 25));
			default: return CH_LA + 8'($urandom_range(0, 25));
		endcase
	endfunction

	// lines of text: each run opens with a pen load, with stray loads and garbage mixed in
	task automatic run_text(input int count);
		int run_left, span_x, span_y;
		logic new_text;
		logic [12:0] ox, oy;
		run_left = 0;
		for (int n = 0; n < count; n++) begin
			new_text = (run_left == 0) || ($urandom_range(0, 15) == 0);
			if (run_left == 0) run_left = $urandom_range(1, 12);
			run_left--;
			span_x = (frame_w > 4000) ? 4000 : int'(frame_w);
			span_y = (frame_h > 4000) ? 4000 : int'(frame_h);
			if (new_text && $urandom_range(0, 3) != 0) begin
				ox = 13'(int'($urandom_range(0, span_x + 20)) - 8 * int'(dot_sc) - 20);
				oy = 13'(int'($urandom_range(0, span_y + 20)) - 8 * int'(dot_sc) - 20);
			end else begin
				ox = 13'($urandom);
				oy = 13'($urandom);
			end
			send_char(rand_char(), new_text, ox, oy, 1'b1);
			maybe_pause();
		end
	endtask

	always @(posedge clk) begin
		if (stall_left != 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			m_tready <= 1'b0;
			stall_left <= $urandom_range(0, 3);
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin : rect_check
		dot_rect_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (due_rects.size() == 0) begin
				$error("rectangle transfer with none expected: x %0d y %0d",
					m_tdata[11:0], m_tdata[23:12]);
				mismatches++;
			end else begin
				want = due_rects.pop_front();
				if (m_tdata[11:0] !== want.x) begin
					$error("rect_x expected %0d got %0d", want.x, m_tdata[11:0]);
					mismatches++;
				end
				if (m_tdata[23:12] !== want.y) begin
					$error("rect_y expected %0d got %0d", want.y, m_tdata[23:12]);
					mismatches++;
				end
				if (m_tdata[28:24] !== want.w) begin
					$error("rect_w expected %0d got %0d", want.w, m_tdata[28:24]);
					mismatches++;
				end
				if (m_tdata[33:29] !== want.h) begin
					$error("rect_h expected %0d got %0d", want.h, m_tdata[33:29]);
					mismatches++;
				end
				if (m_tlast !== want.last) begin
					$error("last_dot expected %0d got %0d", want.last, m_tlast);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("text_glyph_dot_expander_unit_tb failed");
			$finish;
		end
	end

	initial begin : stimulus
		char_row_t row;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_FRAME_WIDTH;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		frame_w = RST_FRAME_WIDTH;
		frame_h = RST_FRAME_HEIGHT;
		dot_sc = RST_DOT_SCALE;
		pen_col = 0;
		pen_row = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_ROWS; i++) begin
			row = CHAR_ROWS[i];
			send_char(row.ch, row.new_text, row.ox, row.oy, !row.typed);
			if (row.typed && row.one_rect) due_rects.push_back(row.rect);
			maybe_pause();
		end

		// largest frame and scale, then a run of spaces that carries the pen far past the edge
		settle();
		program_frame(13'd4096, 13'd4096, 13'd16);
		send_char(8'h57, 1'b1, 13'd4095, 13'd0, 1'b1);
		for (int i = 0; i < 60; i++) send_char(CH_SPACE, 1'b0, 13'($urandom), 13'($urandom), 1'b1);
		send_char(8'h57, 1'b0, 13'd0, 13'd0, 1'b1);
		send_char(CH_0 + 8'd8, 1'b0, 13'd0, 13'd0, 1'b1);
		maybe_pause();
		run_text(12);

		settle();
		program_frame(13'd1, 13'd1, 13'd1);
		run_text(10);

		// oversized frame and scale, plus a write to the unused index
		settle();
		program_frame(13'h1FFF, 13'd5000, 13'h1FFF);
		settle();
		cfg_write(REG_UNUSED, 13'd2);
		cfg_we <= 1'b0;
		run_text(10);

		settle();
		program_frame(13'd640, 13'd480, 13'h1FE0);
		run_text(8);

		settle();
		program_frame(13'd0, 13'd480, 13'd2);
		run_text(8);

		settle();
		program_frame(13'd320, 13'd0, 13'd3);
		run_text(6);

		for (int k = 0; k < 3; k++) begin
			settle();
			program_frame(13'($urandom_range(1, 700)), 13'($urandom_range(1, 520)),
				{8'($urandom), 5'($urandom_range(1, MAX_DOT))});
			run_text(15);
		end

		settle();
		idle_on = 1'b0;
		program_frame(13'd640, 13'd480, 13'd1);
		run_text(30);

		settle();
		if (mismatches == 0 && due_rects.size() == 0) begin
			$display("text_glyph_dot_expander_unit_tb passed");
		end else begin
			$display("text_glyph_dot_expander_unit_tb failed");
		end
		$finish;
	end

endmodule
